// ----- design/mpd_pkg.sv -----
package mpd_pkg;

  // Field widths of one result transaction.
  localparam int unsigned CLASS_W  = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned NIB_W    = 4;
  localparam int unsigned LCNT_W   = 3;
  localparam int unsigned RLEN_W   = 28;
  localparam int unsigned TOTAL_W  = 29;
  localparam int unsigned TOPIC_W  = 16;
  localparam int unsigned SKIP_W   = 17;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned BUFSZ_W  = 16;

  // Packed result word on the master side, padded to whole bytes.
  localparam int unsigned OUT_DATA_W = 72;

  // Result queue between parser and output side.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  // Configuration register indexes.
  localparam int unsigned CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] CFG_BUFFER_SIZE = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_STREAM_MODE = 1'd1;

  localparam logic [BUFSZ_W-1:0] BUFSZ_RESET = 16'd256;

  localparam logic [NIB_W-1:0] TYPE_PUBLISH = 4'd3;

  typedef enum logic [CLASS_W-1:0] {
    CLS_HEADER    = 3'd0,
    CLS_LENGTH    = 3'd1,
    CLS_TOPIC_LEN = 3'd2,
    CLS_SKIPPED   = 3'd3,
    CLS_PAYLOAD   = 3'd4
  } byte_class_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED  = 2'd0,
    ST_DROPPED   = 2'd1,
    ST_MALFORMED = 2'd2
  } status_t;

  // Configuration as seen by the parser.
  typedef struct packed {
    logic [BUFSZ_W-1:0] buffer_size;
    logic               stream_mode;
  } cfg_t;

  // One classified byte.
  typedef struct packed {
    byte_class_t          byte_class;
    logic [BYTE_W-1:0]    data_byte;
    logic [NIB_W-1:0]     packet_type;
    logic [NIB_W-1:0]     header_flags;
    logic [LCNT_W-1:0]    length_bytes;
    logic [RLEN_W-1:0]    remaining_length;
    logic [TOPIC_W-1:0]   topic_length;
    logic                 last;
    status_t              status;
  } res_t;

endpackage

// ----- design/mqtt_packet_deframer_core.sv -----
// Each byte is classified combinationally and its result registered in the queue.
// Throughput: one byte per cycle while the result queue is not full.
// A 4-entry result queue lets the input keep flowing while out_tready is low.
// Reset (rst_n low, synchronous) returns the parser to waiting for a fixed header,
// empties the queue and sets buffer_size to 256 and stream_mode to 0.
module mqtt_packet_deframer_core
  import mpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port.
  input  logic                  cfg_wen,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [BUFSZ_W-1:0]    cfg_wdata,
  // Received bytes.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BYTE_W-1:0]     in_tdata,   // [7:0] rx_byte
  // Classified bytes.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [2:0] byte_class, [10:3] data_byte, [14:11] packet_type, [18:15] header_flags,
  // [21:19] length_bytes, [49:22] remaining_length, [65:50] topic_length,
  // [67:66] status, [71:68] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  cfg_t cfg_r;
  res_t parse_res;
  res_t q_res;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.buffer_size <= BUFSZ_RESET;
      cfg_r.stream_mode <= 1'b0;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        CFG_BUFFER_SIZE: cfg_r.buffer_size <= cfg_wdata;
        CFG_STREAM_MODE: cfg_r.stream_mode <= cfg_wdata[0];
        default:         cfg_r             <= cfg_r;
      endcase
    end
  end

  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready;
  assign pop       = out_tvalid && out_tready;

  mpd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .rx_byte (in_tdata),
    .cfg     (cfg_r),
    .res     (parse_res)
  );

  mpd_res_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (parse_res),
    .full      (q_full),
    .empty     (q_empty),
    .pop       (pop),
    .pop_data  (q_res)
  );

  // Pack the head of the queue onto the master side.
  assign out_tvalid = !q_empty;
  assign out_tlast  = q_res.last;
  assign out_tdata  = {4'd0,
                       q_res.status,
                       q_res.topic_length,
                       q_res.remaining_length,
                       q_res.length_bytes,
                       q_res.header_flags,
                       q_res.packet_type,
                       q_res.data_byte,
                       q_res.byte_class};

endmodule

// ----- design/mpd_parser.sv -----
module mpd_parser
  import mpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [BYTE_W-1:0] rx_byte,
  input  cfg_t              cfg,
  output res_t              res
);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LENGTH = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic [BYTE_W-1:0]    header_r, header_nxt;
  logic [RLEN_W-1:0]    accum_r, accum_nxt;
  logic [LCNT_W-1:0]    lcnt_r, lcnt_nxt;
  logic [RLEN_W-1:0]    body_r, body_nxt;
  logic [TOTAL_W-1:0]   total_r, total_nxt;
  logic [TOPIC_W-1:0]   topic_r, topic_nxt;
  logic [SKIP_W-1:0]    skip_r, skip_nxt;

  logic [RLEN_W-1:0]    addend;
  logic [SKIP_W:0]      skip_end;
  logic [TOTAL_W-1:0]   total_inc;
  logic                 size_drop;
  logic                 is_publish;
  byte_class_t          cls;
  logic                 last;
  status_t              st;

  // Place the 7 data bits of a length byte at its group position.
  always_comb begin
    unique case (lcnt_r[1:0])
      2'd0:    addend = {21'd0, rx_byte[6:0]};
      2'd1:    addend = {14'd0, rx_byte[6:0], 7'd0};
      2'd2:    addend = {7'd0, rx_byte[6:0], 14'd0};
      default: addend = {rx_byte[6:0], 21'd0};
    endcase
  end

  // The size check sees the count that includes the byte ending the packet.
  assign is_publish = (header_r[7:4] == TYPE_PUBLISH);
  assign skip_end   = {1'b0, skip_r} + 18'd2;
  assign total_inc  = total_r + 29'd1;
  assign size_drop  = !cfg.stream_mode && (total_inc > {13'd0, cfg.buffer_size});

  // Next parse state and classification of the incoming byte.
  always_comb begin
    phase_nxt  = phase_r;
    header_nxt = header_r;
    accum_nxt  = accum_r;
    lcnt_nxt   = lcnt_r;
    body_nxt   = body_r;
    total_nxt  = total_r;
    topic_nxt  = topic_r;
    skip_nxt   = skip_r;
    cls        = CLS_HEADER;
    last       = 1'b0;
    st         = ST_ACCEPTED;
    unique case (phase_r)
      PH_LENGTH: begin
        total_nxt = total_inc;
        accum_nxt = accum_r + addend;
        lcnt_nxt  = lcnt_r + 3'd1;
        cls       = CLS_LENGTH;
        if (rx_byte[7]) begin
          if (lcnt_nxt >= 3'd4) begin
            last      = 1'b1;
            st        = ST_MALFORMED;
            phase_nxt = PH_HEADER;
          end
        end else if (accum_nxt == '0) begin
          last      = 1'b1;
          st        = size_drop ? ST_DROPPED : ST_ACCEPTED;
          phase_nxt = PH_HEADER;
        end else begin
          phase_nxt = PH_BODY;
        end
      end
      PH_BODY: begin
        body_nxt  = body_r + 28'd1;
        total_nxt = total_inc;
        if (is_publish) begin
          if (body_r == 28'd0) begin
            topic_nxt = {rx_byte, 8'd0};
            cls       = CLS_TOPIC_LEN;
          end else if (body_r == 28'd1) begin
            topic_nxt = topic_r | {8'd0, rx_byte};
            skip_nxt  = {1'b0, topic_nxt} + ((header_r[2:1] != 2'b00) ? 17'd2 : 17'd0);
            cls       = CLS_TOPIC_LEN;
          end else if (body_r < {10'd0, skip_end}) begin
            cls = CLS_SKIPPED;
          end else begin
            cls = CLS_PAYLOAD;
          end
        end else begin
          cls = CLS_PAYLOAD;
        end
        if (body_nxt == accum_r) begin
          last      = 1'b1;
          st        = size_drop ? ST_DROPPED : ST_ACCEPTED;
          phase_nxt = PH_HEADER;
        end
      end
      default: begin
        header_nxt = rx_byte;
        accum_nxt  = '0;
        lcnt_nxt   = '0;
        body_nxt   = '0;
        total_nxt  = 29'd1;
        topic_nxt  = '0;
        skip_nxt   = '0;
        phase_nxt  = PH_LENGTH;
        cls        = CLS_HEADER;
      end
    endcase
  end

  // Result of the byte accepted in this cycle.
  always_comb begin
    res.byte_class       = cls;
    res.data_byte        = rx_byte;
    res.packet_type      = header_nxt[7:4];
    res.header_flags     = header_nxt[3:0];
    res.length_bytes     = lcnt_nxt;
    res.remaining_length = accum_nxt;
    res.topic_length     = topic_nxt;
    res.last             = last;
    res.status           = st;
  end

  // Parse state advances only on an accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      header_r <= '0;
      accum_r  <= '0;
      lcnt_r   <= '0;
      body_r   <= '0;
      total_r  <= '0;
      topic_r  <= '0;
      skip_r   <= '0;
    end else if (push) begin
      phase_r  <= phase_nxt;
      header_r <= header_nxt;
      accum_r  <= accum_nxt;
      lcnt_r   <= lcnt_nxt;
      body_r   <= body_nxt;
      total_r  <= total_nxt;
      topic_r  <= topic_nxt;
      skip_r   <= skip_nxt;
    end
  end

  // A nonzero status appears only on the byte that ends a packet.
  a_status_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (push && res.status != ST_ACCEPTED) |-> res.last)
    else $error("nonzero status without packet end");

  // After a packet end the next byte is taken as a fixed header.
  a_last_to_header: assert property (@(posedge clk) disable iff (!rst_n)
    (push && res.last) |=> (phase_r == PH_HEADER))
    else $error("parser did not return to header phase");

  // No more than four length bytes are ever counted.
  a_lcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lcnt_r <= 3'd4)
    else $error("length byte count out of range");

  // A header byte always opens the length phase.
  a_header_to_length: assert property (@(posedge clk) disable iff (!rst_n)
    (push && phase_r == PH_HEADER) |=> (phase_r == PH_LENGTH && total_r == 29'd1))
    else $error("header byte did not start length phase");

endmodule

// ----- design/mpd_res_queue.sv -----
module mpd_res_queue
  import mpd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_data,
  output logic full,
  output logic empty,
  input  logic pop,
  output res_t pop_data
);

  res_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == QCNT_W'(QDEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (!push && pop) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  // Storage for queued results.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full result queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty result queue");

  // Fill count agrees with the pointer distance.
  a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r[QPTR_W-1:0] == (wr_ptr_r - rd_ptr_r)) && (count_r <= QCNT_W'(QDEPTH)))
    else $error("queue count and pointers disagree");

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import mpd_pkg::*;

  localparam int unsigned STALL_LIMIT = 200;
  localparam int unsigned SETTLE_CYCLES = 4;

  typedef enum logic [1:0] {
    AWAIT_HEADER,
    IN_LENGTH,
    IN_BODY
  } parse_phase_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wen = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = CFG_BUFFER_SIZE;
  logic [BUFSZ_W-1:0]    cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  // Bytes waiting to be sent and classifications waiting to be seen.
  logic [BYTE_W-1:0] rx_stream[$];
  res_t              class_queue[$];

  int unsigned queued_bytes = 0;
  int unsigned in_hold = 0;
  int unsigned out_hold = 0;
  bit          idle_en = 1'b1;
  int unsigned errors = 0;
  int unsigned n_checked = 0;
  int unsigned n_packets = 0;
  int unsigned n_dropped = 0;
  int unsigned n_malformed = 0;

  // Parser copy kept by the testbench.
  logic [BUFSZ_W-1:0] buf_limit = BUFSZ_RESET;
  logic               stream_on = 1'b0;
  parse_phase_t       ph = AWAIT_HEADER;
  logic [7:0]         hdr_byte = '0;
  logic [RLEN_W-1:0]  len_acc = '0;
  logic [LCNT_W-1:0]  len_cnt = '0;
  logic [RLEN_W-1:0]  body_cnt = '0;
  logic [TOTAL_W-1:0] tot_cnt = '0;
  logic [TOPIC_W-1:0] topic_len = '0;
  logic [SKIP_W-1:0]  skip_cnt = '0;

  mqtt_packet_deframer_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #4 clk = ~clk;

  // The size check that applies when a packet ends normally.
  function automatic status_t size_verdict();
    if (!stream_on && tot_cnt > {13'd0, buf_limit}) return ST_DROPPED;
    return ST_ACCEPTED;
  endfunction

  // Advance the parser copy by one byte and record the classification it implies.
  task automatic classify_byte(input logic [7:0] b);
    res_t              r;
    logic [RLEN_W-1:0] idx;
    r = '0;
    r.byte_class = CLS_HEADER;
    r.status = ST_ACCEPTED;
    case (ph)
      IN_LENGTH: begin
        tot_cnt = tot_cnt + TOTAL_W'(1);
        len_acc = len_acc + (RLEN_W'(b[6:0]) << (7 * len_cnt[1:0]));
        len_cnt = len_cnt + LCNT_W'(1);
        r.byte_class = CLS_LENGTH;
        if (b[7]) begin
          // A continuation flag on the fourth length byte ends the packet as malformed.
          if (len_cnt >= 3'd4) begin
            r.last = 1'b1;
            r.status = ST_MALFORMED;
            ph = AWAIT_HEADER;
          end
        end else if (len_acc == '0) begin
          r.last = 1'b1;
          r.status = size_verdict();
          ph = AWAIT_HEADER;
        end else begin
          ph = IN_BODY;
        end
      end
      IN_BODY: begin
        idx = body_cnt;
        body_cnt = body_cnt + RLEN_W'(1);
        tot_cnt = tot_cnt + TOTAL_W'(1);
        if (hdr_byte[7:4] == TYPE_PUBLISH) begin
          if (idx == '0) begin
            topic_len = {b, 8'h00};
            r.byte_class = CLS_TOPIC_LEN;
          end else if (idx == RLEN_W'(1)) begin
            topic_len = topic_len | {8'h00, b};
            // Any nonzero QoS, three included, adds a two-byte message id.
            skip_cnt = {1'b0, topic_len} + ((hdr_byte[2:1] != 2'b00) ? 17'd2 : 17'd0);
            r.byte_class = CLS_TOPIC_LEN;
          end else if ({1'b0, idx} < (29'd2 + TOTAL_W'(skip_cnt))) begin
            r.byte_class = CLS_SKIPPED;
          end else begin
            r.byte_class = CLS_PAYLOAD;
          end
        end else begin
          r.byte_class = CLS_PAYLOAD;
        end
        if (body_cnt == len_acc) begin
          r.last = 1'b1;
          r.status = size_verdict();
          ph = AWAIT_HEADER;
        end
      end
      default: begin
        hdr_byte = b;
        len_acc = '0;
        len_cnt = '0;
        body_cnt = '0;
        tot_cnt = TOTAL_W'(1);
        topic_len = '0;
        skip_cnt = '0;
        ph = IN_LENGTH;
      end
    endcase
    r.data_byte = b;
    r.packet_type = hdr_byte[7:4];
    r.header_flags = hdr_byte[3:0];
    r.length_bytes = len_cnt;
    r.remaining_length = len_acc;
    r.topic_length = topic_len;
    class_queue.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Compare one output transaction with the oldest expected classification.
  task automatic check_result();
    res_t want;
    if (class_queue.size() == 0) begin
      $display("%0t: unexpected output transaction: expected none, actual tdata %0h",
               $time, out_tdata);
      errors++;
    end else begin
      want = class_queue.pop_front();
      check_field("byte_class", 32'(want.byte_class), 32'(out_tdata[2:0]));
      check_field("data_byte", 32'(want.data_byte), 32'(out_tdata[10:3]));
      check_field("packet_type", 32'(want.packet_type), 32'(out_tdata[14:11]));
      check_field("header_flags", 32'(want.header_flags), 32'(out_tdata[18:15]));
      check_field("length_bytes", 32'(want.length_bytes), 32'(out_tdata[21:19]));
      check_field("remaining_length", 32'(want.remaining_length), 32'(out_tdata[49:22]));
      check_field("topic_length", 32'(want.topic_length), 32'(out_tdata[65:50]));
      check_field("last", 32'(want.last), 32'(out_tlast));
      check_field("status", 32'(want.status), 32'(out_tdata[67:66]));
      n_checked++;
      if (out_tlast) begin
        n_packets++;
        if (out_tdata[67:66] == ST_DROPPED) n_dropped++;
        if (out_tdata[67:66] == ST_MALFORMED) n_malformed++;
      end
    end
  endtask

  // Driver: predicts each accepted byte, then offers the next one or idles.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) classify_byte(in_tdata);
      if (!in_tvalid || in_tready) begin
        if (in_hold > 0) begin
          in_hold--;
          in_tvalid <= 1'b0;
        end else if (rx_stream.size() > 0) begin
          in_tdata <= rx_stream.pop_front();
          in_tvalid <= 1'b1;
          if (idle_en && $urandom_range(0, 5) == 0) in_hold = $urandom_range(1, 5);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each output transaction and stalls the output in bursts.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) check_result();
      if (out_hold > 0) begin
        out_hold--;
        out_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_hold = $urandom_range(0, 4);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when work is outstanding but nothing moves.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (rx_stream.size() == 0 && class_queue.size() == 0 && !in_tvalid))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no transaction for %0d cycles, %0d results outstanding",
             $time, STALL_LIMIT, class_queue.size());
    $display("*** FAILED ***");
    $finish;
  end

  task automatic queue_byte(input logic [7:0] b);
    rx_stream.push_back(b);
    queued_bytes++;
  endtask

  // Header, remaining length in nlen groups (possibly padded with zero groups), then body.
  // A PUBLISH body starts with the big-endian topic length.
  task automatic queue_packet(input logic [7:0] hdr, input int unsigned rem,
                              input int unsigned nlen, input logic [15:0] tlen);
    queue_byte(hdr);
    for (int unsigned i = 0; i < nlen; i++)
      queue_byte({(i + 1 < nlen) ? 1'b1 : 1'b0, 7'((rem >> (7 * i)) & 127)});
    for (int unsigned i = 0; i < rem; i++) begin
      if (hdr[7:4] == TYPE_PUBLISH && i == 0) queue_byte(tlen[15:8]);
      else if (hdr[7:4] == TYPE_PUBLISH && i == 1) queue_byte(tlen[7:0]);
      else queue_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Mostly well-formed PUBLISH and other packets; the rest short, malformed or padded.
  task automatic queue_random_packet();
    int unsigned pick;
    int unsigned tlen;
    int unsigned plen;
    int unsigned rem;
    logic [3:0]  flags;
    pick = $urandom_range(0, 99);
    flags = 4'($urandom_range(0, 15));
    if (pick < 45) begin
      tlen = $urandom_range(0, 6);
      plen = ($urandom_range(0, 39) == 0) ? $urandom_range(120, 190) : $urandom_range(0, 8);
      rem = 2 + tlen + ((flags[2:1] != 2'b00) ? 2 : 0) + plen;
      queue_packet({TYPE_PUBLISH, flags}, rem, (rem < 128) ? 1 : 2, 16'(tlen));
    end else if (pick < 75) begin
      queue_packet(8'($urandom_range(0, 255)), $urandom_range(0, 10), 1,
                   16'($urandom_range(0, 65535)));
    end else if (pick < 85) begin
      queue_packet({TYPE_PUBLISH, flags}, $urandom_range(0, 4), 1,
                   16'($urandom_range(0, 65535)));
    end else if (pick < 93) begin
      queue_byte(8'($urandom_range(0, 255)));
      repeat (4) queue_byte({1'b1, 7'($urandom_range(0, 127))});
    end else begin
      queue_packet(8'($urandom_range(0, 255)), $urandom_range(0, 5), $urandom_range(2, 4),
                   16'($urandom_range(0, 65535)));
    end
  endtask

  task automatic queue_random(input int unsigned n);
    int unsigned start;
    start = queued_bytes;
    while (queued_bytes - start < n) queue_random_packet();
  endtask

  // Wait until every byte is sent and classified, then let the pipeline settle.
  task automatic drain();
    while (rx_stream.size() != 0 || in_tvalid || class_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers on consecutive cycles while the block is idle.
  task automatic write_cfg(input logic [BUFSZ_W-1:0] bsize, input logic smode);
    cfg_wen <= 1'b1;
    cfg_addr <= CFG_BUFFER_SIZE;
    cfg_wdata <= bsize;
    @(posedge clk);
    cfg_addr <= CFG_STREAM_MODE;
    cfg_wdata <= {15'd0, smode};
    @(posedge clk);
    cfg_wen <= 1'b0;
    buf_limit = bsize;
    stream_on = smode;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed packets under the reset configuration.
    queue_packet(8'hC0, 0, 1, 16'h0000);
    queue_packet(8'hE0, 0, 2, 16'h0000);
    queue_byte(8'h3F);
    repeat (4) queue_byte(8'hFF);
    queue_packet(8'h32, 7, 1, 16'h0002);
    queue_packet(8'h30, 1, 1, 16'hFFFF);
    queue_packet(8'h36, 3, 1, 16'h0005);
    queue_packet(8'hFF, 2, 1, 16'h0000);
    queue_random(40);
    drain();

    write_cfg(16'hFFFF, 1'b0);
    queue_random(70);
    drain();

    // With a zero limit every well-formed packet is dropped.
    write_cfg(16'h0000, 1'b0);
    queue_random(60);
    drain();

    write_cfg(16'h0001, 1'b1);
    queue_random(60);
    drain();

    write_cfg(16'($urandom_range(4, 40)), 1'b0);
    queue_random(70);
    drain();

    write_cfg(16'($urandom_range(4, 40)), 1'b1);
    queue_random(60);
    drain();

    // Final stretch at full rate on both sides.
    idle_en = 1'b0;
    write_cfg(16'($urandom_range(8, 30)), 1'b0);
    queue_random(70);
    drain();

    $display("Checked %0d classified bytes over %0d packets (%0d dropped, %0d malformed),",
             n_checked, n_packets, n_dropped, n_malformed);
    $display("across seven register settings with random stalls on both sides.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- mqtt_packet_deframer_core.f -----
design/mpd_pkg.sv
design/mpd_parser.sv
design/mpd_res_queue.sv
design/mqtt_packet_deframer_core.sv
test/testbench.sv
